// ===== hw/rtl/int64_to_radix_digits_core_defines.svh =====
// Assertion macros shared by the radix digit converter RTL.
`ifndef INT64_TO_RADIX_DIGITS_CORE_DEFINES_SVH
`define INT64_TO_RADIX_DIGITS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset only.
`define I64RDX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define I64RDX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define I64RDX_ASSERT(label, prop, msg)
`define I64RDX_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/i64rdx_pkg.sv =====
// Package with types, constants and helper functions of the radix digit converter.
package i64rdx_pkg;

  // Field widths.
  localparam int ValueW      = 64;
  localparam int DigitW      = 6;
  localparam int CharW       = 7;

  // Digit buffer geometry.
  localparam int MaxDigits   = 64;
  localparam int IdxW        = $clog2(MaxDigits);

  // Divider: quotient bits resolved per cycle and number of divider steps per digit.
  localparam int BitsPerCycle = 8;
  localparam int DivSteps     = ValueW / BitsPerCycle;
  localparam int DivCntW      = $clog2(DivSteps);

  // Radix range and character codes.
  localparam logic [DigitW-1:0] RadixMin     = DigitW'(2);
  localparam logic [DigitW-1:0] RadixMax     = DigitW'(36);
  localparam logic [DigitW-1:0] DecimalLimit = DigitW'(10);
  localparam logic [CharW-1:0]  DigitZero    = CharW'(48);
  localparam logic [CharW-1:0]  LetterBase   = CharW'(65);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FETCH,
    ST_EMIT
  } state_e;

  // Request to the divider.
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] dividend;
    logic [DigitW-1:0] divisor;
  } div_req_t;

  // Status from the divider.
  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_stat_t;

  // Force a radix into the supported range.
  function automatic logic [DigitW-1:0] clamp_radix(input logic [DigitW-1:0] r);
    logic [DigitW-1:0] res;
    res = r;
    if (r < RadixMin) begin
      res = RadixMin;
    end else if (r > RadixMax) begin
      res = RadixMax;
    end
    return res;
  endfunction

  // Map a digit value to its ASCII code.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] res;
    if (d < DecimalLimit) begin
      res = DigitZero + CharW'(d);
    end else begin
      res = LetterBase + CharW'(d - DecimalLimit);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/i64rdx_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module i64rdx_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/i64rdx_divider.sv =====
// Iterative divider of a 64-bit magnitude by a small radix, several bits per cycle.
module i64rdx_divider
  import i64rdx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output div_stat_t         stat_o,
  output logic [ValueW-1:0] quotient_o,
  output logic [DigitW-1:0] remainder_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0]  dividend_q;
  logic [DigitW-1:0]  rem_q;
  logic [DigitW-1:0]  divisor_q;
  logic [ValueW-1:0]  step_quo;
  logic [DigitW-1:0]  step_rem;

  // Restoring division, one step per quotient bit of this cycle: shift in a dividend bit, compare and subtract.
  always_comb begin
    logic [DigitW:0]   part;
    logic [ValueW-1:0] quo;
    logic [DigitW-1:0] rem;
    quo  = dividend_q;
    rem  = rem_q;
    part = '0;
    for (int i = 0; i < BitsPerCycle; i++) begin
      part = {rem, quo[ValueW-1]};
      quo  = {quo[ValueW-2:0], 1'b0};
      if (part >= {1'b0, divisor_q}) begin
        part   = part - {1'b0, divisor_q};
        quo[0] = 1'b1;
      end
      rem = part[DigitW-1:0];
    end
    step_quo = quo;
    step_rem = rem;
  end

  // Step counter and completion flag.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers; the dividend register turns into the quotient.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dividend_q <= req_i.dividend;
      rem_q      <= '0;
      divisor_q  <= req_i.divisor;
    end else if (busy_q) begin
      dividend_q <= step_quo;
      rem_q      <= step_rem;
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.quo_zero = (dividend_q == '0);
  assign quotient_o      = dividend_q;
  assign remainder_o     = rem_q;

endmodule

// ===== hw/rtl/int64_to_radix_digits_core.sv =====
// Top level of the signed 64-bit to radix 2..36 ASCII digit converter.
//
//   channel  direction  handshake               beat payload
//   in       sink       in_valid_i / in_stall_o  value_i, radix_i
//   out      source     out_valid_o / out_stall_i character_o, minus_first_o, last_o
//
// Each digit costs one pass through the shared divider, which resolves 8 quotient bits
// at a time, plus one step to store the remainder and restart; output stalls lengthen an item.
// Digits go into a 64-entry buffer least significant first and are read back in reverse.
// One input item is worked on at a time; in_stall_o is high from acceptance until
// the last digit beat has been taken. Reset returns the sequencer to idle.
`include "int64_to_radix_digits_core_defines.svh"

module int64_to_radix_digits_core
  import i64rdx_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ValueW-1:0] value_i,
  input  logic        [DigitW-1:0] radix_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [CharW-1:0]  character_o,
  output logic                     minus_first_o,
  output logic                     last_o
);

  state_e            state_q, state_d;
  logic [IdxW-1:0]   ndig_q, ndig_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              neg_q, neg_d;
  logic [DigitW-1:0] rdx_q, rdx_d;
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [ValueW-1:0] div_quot;
  logic [DigitW-1:0] div_rem;
  logic [ValueW-1:0] value_u;
  logic [ValueW-1:0] magnitude;
  logic              wr_en;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic [DigitW-1:0] rd_digit;
  logic              in_fire;
  logic              out_fire;

  // Magnitude modulo 2^64.
  assign value_u   = $unsigned(value_i);
  assign magnitude = value_u[ValueW-1] ? (~value_u + ValueW'(1)) : value_u;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // Sequencer: divide until the quotient is zero, then play the buffer back.
  // The clamped radix is kept for the whole item, since the input may change.
  always_comb begin
    state_d          = state_q;
    ndig_d           = ndig_q;
    idx_d            = idx_q;
    neg_d            = neg_q;
    rdx_d            = rdx_q;
    div_req.start    = 1'b0;
    div_req.dividend = div_quot;
    div_req.divisor  = rdx_q;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          div_req.start    = 1'b1;
          div_req.dividend = magnitude;
          div_req.divisor  = clamp_radix(radix_i);
          rdx_d            = clamp_radix(radix_i);
          neg_d            = value_u[ValueW-1];
          ndig_d           = '0;
          state_d          = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          wr_en = 1'b1;
          if (div_stat.quo_zero || (ndig_q == IdxW'(MaxDigits - 1))) begin
            idx_d   = ndig_q;
            state_d = ST_FETCH;
          end else begin
            ndig_d        = ndig_q + IdxW'(1);
            div_req.start = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - IdxW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_q - IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ndig_q  <= '0;
      idx_q   <= '0;
      neg_q   <= 1'b0;
      rdx_q   <= RadixMin;
    end else begin
      state_q <= state_d;
      ndig_q  <= ndig_d;
      idx_q   <= idx_d;
      neg_q   <= neg_d;
      rdx_q   <= rdx_d;
    end
  end

  // Shared divider.
  i64rdx_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Digit buffer, written least significant digit first.
  i64rdx_ram #(
    .Width (DigitW),
    .Depth (MaxDigits)
  ) u_digit_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (ndig_q),
    .wr_data_i (div_rem),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_digit)
  );

  // Output beat.
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign character_o   = digit_char(rd_digit);
  assign minus_first_o = neg_q && (idx_q == ndig_q);
  assign last_o        = (idx_q == '0);

  // Checks on the sequencing.
  `I64RDX_ASSERT(a_emit_blocks_input, out_valid_o |-> in_stall_o, "input taken while emitting")
  `I64RDX_ASSERT(a_last_ends_item, (out_fire && last_o) |=> !out_valid_o, "beat after last digit")
  `I64RDX_ASSERT(a_no_early_output, in_fire |=> !out_valid_o, "output right after accept")
  `I64RDX_ASSERT_ALWAYS(a_done_in_divide, div_stat.done |-> (state_q == ST_DIVIDE), "stray done")

endmodule
